FILE: sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bif_pkg.sv
// types, constants and weight table functions of the bilateral image filter
package bif_pkg;

  localparam int unsigned FRAME_W    = 12;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR_MODE   = 2'd2;

  localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic               RST_COLOR_MODE   = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] width;
    logic [FRAME_W-1:0] height;
    logic               color_mode;
  } frame_cfg_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue_centre;
    logic issue_tap;
    logic div_init;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic div_last;
  } ctrl_stat_t;

  // shift-subtract division, used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series of exp(-f), f in q.31
  function automatic logic [63:0] exp_series(input logic [63:0] f);
    logic signed [64:0] sum;
    logic [63:0]        term;
    logic               done;
    sum  = 65'sh0_8000_0000;
    term = 64'h8000_0000;
    done = 1'b0;
    for (int t = 1; t <= 24; t++) begin
      if (!done) begin
        term = udiv64((term * f) >> 31, 64'(t));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (t[0]) begin
          sum = sum - $signed({1'b0, term});
        end else begin
          sum = sum + $signed({1'b0, term});
        end
      end
    end
    if (sum < 0) sum = '0;
    return sum[63:0];
  endfunction

  // exp(-n/d) as unsigned q0.wb
  function automatic logic [31:0] weight_of(input logic [63:0] n, input logic [63:0] d,
                                            input int unsigned wb);
    logic [63:0] x;
    logic [63:0] k;
    logic [63:0] e;
    logic [63:0] e1;
    logic [63:0] w;
    logic [63:0] wmax;
    if (d == 64'd0 || n >= (d << 5)) return 32'd0;
    x  = udiv64(n << 31, d);
    k  = x >> 31;
    e  = exp_series(x & 64'h7FFF_FFFF);
    e1 = exp_series(64'h8000_0000);
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < k) e = (e * e1 + 64'h4000_0000) >> 31;
    end
    w    = ((e << wb) + 64'h4000_0000) >> 31;
    wmax = (64'd1 << wb) - 64'd1;
    return 32'((w > wmax) ? wmax : w);
  endfunction

endpackage

FILE: sv/bilateral_image_filter.sv
// top level of the bilateral image filter: config registers, controller and datapath
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_item_t (pixel or flush tick)
//   out_     output     out_valid / out_ready   out_item_t (filtered pixel)
//   cfg      input      psel / penable / pwrite frame_width, frame_height, color_mode
//
// an item that produces no result is taken while the controller stays idle
// an item that produces a result busies the controller with one line-store read per tap,
// a 3-stage weighting pipeline and an 8-step divider
// rst_n is synchronous; the line store holds no reset and needs no clearing pass
// a held result in the output register stalls only the load of the next result
`include "assert_macros.svh"

module bilateral_image_filter import bif_pkg::*; #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned SPACE_SIGMA = 10,
  parameter int unsigned COLOR_SIGMA = 30,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned HALF = (WINDOW - 1) / 2;
  localparam int unsigned NTAP = (2 * HALF + 1) * (2 * HALF + 1);

  logic [FRAME_W-1:0] frame_width_r, frame_height_r;
  logic               color_mode_r;
  logic               cfg_wr, cfg_restart;
  logic [1:0]         cfg_idx;
  logic [FRAME_W-1:0] w0;
  frame_cfg_t         cfg;
  ctrl_cmd_t          cmd;
  ctrl_stat_t         st;

  assign pready      = 1'b1;
  assign cfg_idx     = paddr[3:2];
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_restart = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT
                                  || cfg_idx == REG_COLOR_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      color_mode_r   <= RST_COLOR_MODE;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_FRAME_WIDTH)  frame_width_r  <= pwdata[FRAME_W-1:0];
      if (cfg_idx == REG_FRAME_HEIGHT) frame_height_r <= pwdata[FRAME_W-1:0];
      if (cfg_idx == REG_COLOR_MODE)   color_mode_r   <= pwdata[0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      REG_COLOR_MODE:   prdata = CFG_DATA_W'(color_mode_r);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  assign w0 = (frame_width_r == '0) ? 12'd1 : frame_width_r;
  assign cfg.width = ({1'b0, w0} > 13'(MAX_WIDTH)) ? FRAME_W'(MAX_WIDTH) : w0;
  assign cfg.height = (frame_height_r == '0) ? 12'd1 : frame_height_r;
  assign cfg.color_mode = color_mode_r;

  bif_ctrl #(
    .NTAP (NTAP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bif_datapath #(
    .WINDOW      (WINDOW),
    .MAX_WIDTH   (MAX_WIDTH),
    .SPACE_SIGMA (SPACE_SIGMA),
    .COLOR_SIGMA (COLOR_SIGMA),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg         (cfg),
    .cfg_restart (cfg_restart),
    .cmd         (cmd),
    .st          (st),
    .out_data    (out_data)
  );

  `ASSERT_NEVER(a_no_overwrite, cmd.load && out_valid && !out_ready)
  `ASSERT_NEXT(a_busy_after_start, cmd.start, !in_ready)
  `ASSERT_NEVER(a_issue_vs_divide, (cmd.issue_centre || cmd.issue_tap) && cmd.div_step)

endmodule

FILE: sv/bif_ctrl.sv
// controller state machine of the bilateral image filter
module bif_ctrl import bif_pkg::*; #(
  parameter int unsigned NTAP = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_stat_t st,
  output ctrl_cmd_t  cmd
);

  localparam int unsigned CNT_W = $clog2(NTAP + 5);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GATHER = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.emit_req) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_GATHER;
          end
        end
      end
      S_GATHER: begin
        if (cnt_r == '0) begin
          cmd.issue_centre = 1'b1;
        end else if (cnt_r <= CNT_W'(NTAP)) begin
          cmd.issue_tap = 1'b1;
        end
        if (cnt_r == CNT_W'(NTAP + 4)) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load) ov_nxt = 1'b1;
    else if (out_ready)    ov_nxt = 1'b0;
    else                   ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule

FILE: sv/bif_datapath.sv
// line store, tap pipeline, divider and frame counters of the bilateral image filter
module bif_datapath import bif_pkg::*; #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned SPACE_SIGMA = 10,
  parameter int unsigned COLOR_SIGMA = 30,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  frame_cfg_t cfg,
  input  logic       cfg_restart,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t st,
  output out_item_t  out_data
);

  localparam int unsigned HALF      = (WINDOW - 1) / 2;
  localparam int unsigned TAPS      = 2 * HALF + 1;
  localparam int unsigned NTAP      = TAPS * TAPS;
  localparam int unsigned ROW_SLOTS = 2 * WINDOW;
  localparam int unsigned SLOT_W    = $clog2(ROW_SLOTS);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ADDR_W    = SLOT_W + COL_W;
  localparam int unsigned TAP_W     = $clog2(TAPS);
  localparam int unsigned SPN       = 2 * HALF * HALF + 1;
  localparam int unsigned DIST_W    = $clog2(SPN);
  localparam int unsigned SPT       = 1 << DIST_W;
  localparam int unsigned WB        = WEIGHT_BITS;
  localparam int unsigned DEN_W     = WB + $clog2(NTAP + 1);
  localparam int unsigned NUM_W     = DEN_W + 8;
  localparam int unsigned ICNT_W    = 2 * FRAME_W;

  typedef logic [WB-1:0] rtab_t [256];
  typedef logic [WB-1:0] stab_t [SPT];

  function automatic rtab_t build_range();
    rtab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = WB'(weight_of(64'(i * i), 64'(2 * COLOR_SIGMA * COLOR_SIGMA), WB));
    end
    return tab;
  endfunction

  function automatic stab_t build_space();
    stab_t tab;
    for (int i = 0; i < SPT; i++) begin
      tab[i] = WB'(weight_of(64'(i), 64'(2 * SPACE_SIGMA * SPACE_SIGMA), WB));
    end
    return tab;
  endfunction

  localparam rtab_t RANGE_TAB = build_range();
  localparam stab_t SPACE_TAB = build_space();

  // frame position
  logic [COL_W-1:0]   wr_col_r, wr_col_nxt;
  logic [FRAME_W-1:0] wr_row_r, wr_row_nxt;
  logic [SLOT_W-1:0]  wr_slot_r, wr_slot_nxt;
  logic [ICNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [COL_W-1:0]   o_col_r, o_col_nxt;
  logic [FRAME_W-1:0] o_row_r, o_row_nxt;
  logic [SLOT_W-1:0]  o_slot_r, o_slot_nxt;

  logic               is_pixel, is_flush, frame_full, restart_now;
  logic [ICNT_W-1:0]  delay_w, in_cnt_eff;
  logic [FRAME_W-1:0] o_row_eff;
  logic [COL_W-1:0]   wc;
  logic [FRAME_W-1:0] wrw;
  logic [SLOT_W-1:0]  ws;

  assign is_pixel    = in_data.req_type == REQ_PIXEL;
  assign is_flush    = in_data.req_type == REQ_FLUSH;
  assign frame_full  = wr_row_r >= cfg.height;
  assign restart_now = is_pixel && frame_full;
  assign delay_w     = ICNT_W'(HALF) * ICNT_W'(cfg.width) + ICNT_W'(HALF);
  assign in_cnt_eff  = restart_now ? '0 : in_cnt_r;
  assign o_row_eff   = restart_now ? '0 : o_row_r;
  assign wc          = restart_now ? '0 : wr_col_r;
  assign wrw         = restart_now ? '0 : wr_row_r;
  assign ws          = restart_now ? '0 : wr_slot_r;

  assign st.emit_req = (is_pixel && in_cnt_eff >= delay_w && o_row_eff < cfg.height)
                    || (is_flush && frame_full && o_row_r < cfg.height);

  always_comb begin
    wr_col_nxt  = wr_col_r;
    wr_row_nxt  = wr_row_r;
    wr_slot_nxt = wr_slot_r;
    in_cnt_nxt  = in_cnt_r;
    o_col_nxt   = o_col_r;
    o_row_nxt   = o_row_r;
    o_slot_nxt  = o_slot_r;
    priority if (cfg_restart) begin
      wr_col_nxt  = '0;
      wr_row_nxt  = '0;
      wr_slot_nxt = '0;
      in_cnt_nxt  = '0;
      o_col_nxt   = '0;
      o_row_nxt   = '0;
      o_slot_nxt  = '0;
    end else if (cmd.accept && is_pixel) begin
      in_cnt_nxt = in_cnt_eff + 1'b1;
      if (restart_now) begin
        o_col_nxt  = '0;
        o_row_nxt  = '0;
        o_slot_nxt = '0;
      end
      if (FRAME_W'(wc) + 1'b1 >= cfg.width) begin
        wr_col_nxt  = '0;
        wr_row_nxt  = wrw + 1'b1;
        wr_slot_nxt = (ws == SLOT_W'(ROW_SLOTS - 1)) ? '0 : ws + 1'b1;
      end else begin
        wr_col_nxt  = wc + 1'b1;
        wr_row_nxt  = wrw;
        wr_slot_nxt = ws;
      end
    end else if (cmd.load) begin
      if (FRAME_W'(o_col_r) == cfg.width - 1'b1) begin
        o_col_nxt  = '0;
        o_row_nxt  = o_row_r + 1'b1;
        o_slot_nxt = (o_slot_r == SLOT_W'(ROW_SLOTS - 1)) ? '0 : o_slot_r + 1'b1;
      end else begin
        o_col_nxt = o_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_col_r  <= '0;
      wr_row_r  <= '0;
      wr_slot_r <= '0;
      in_cnt_r  <= '0;
      o_col_r   <= '0;
      o_row_r   <= '0;
      o_slot_r  <= '0;
    end else begin
      wr_col_r  <= wr_col_nxt;
      wr_row_r  <= wr_row_nxt;
      wr_slot_r <= wr_slot_nxt;
      in_cnt_r  <= in_cnt_nxt;
      o_col_r   <= o_col_nxt;
      o_row_r   <= o_row_nxt;
      o_slot_r  <= o_slot_nxt;
    end
  end

  // tap address generation
  logic [TAP_W-1:0] ty_r, tx_r;
  logic signed [13:0] dy_s, dx_s, rr_s, rrc_s, h_last_s, w_last_s;
  logic signed [13:0] slot_raw_s, slot_s, cc_s, ccl_s, dist_s;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIST_W-1:0]  dist2;
  logic               rd_en;

  assign rd_en = cmd.issue_centre || cmd.issue_tap;

  always_comb begin
    dy_s     = cmd.issue_centre ? 14'sd0 : $signed(14'(ty_r)) - $signed(14'(HALF));
    dx_s     = cmd.issue_centre ? 14'sd0 : $signed(14'(tx_r)) - $signed(14'(HALF));
    h_last_s = $signed({2'b00, cfg.height}) - 14'sd1;
    w_last_s = $signed({2'b00, cfg.width}) - 14'sd1;
    rr_s     = $signed({2'b00, o_row_r}) + dy_s;
    if (rr_s < 0)             rrc_s = 14'sd0;
    else if (rr_s > h_last_s) rrc_s = h_last_s;
    else                      rrc_s = rr_s;
    slot_raw_s = $signed(14'(o_slot_r)) + (rrc_s - $signed({2'b00, o_row_r}));
    if (slot_raw_s < 0)
      slot_s = slot_raw_s + $signed(14'(ROW_SLOTS));
    else if (slot_raw_s >= $signed(14'(ROW_SLOTS)))
      slot_s = slot_raw_s - $signed(14'(ROW_SLOTS));
    else
      slot_s = slot_raw_s;
    cc_s = $signed(14'(o_col_r)) + dx_s;
    if (cc_s < 0)             ccl_s = 14'sd0;
    else if (cc_s > w_last_s) ccl_s = w_last_s;
    else                      ccl_s = cc_s;
    dist_s  = dy_s * dy_s + dx_s * dx_s;
    dist2   = dist_s[DIST_W-1:0];
    rd_addr = {slot_s[SLOT_W-1:0], ccl_s[COL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ty_r <= '0;
      tx_r <= '0;
    end else if (cmd.start) begin
      ty_r <= '0;
      tx_r <= '0;
    end else if (cmd.issue_tap) begin
      if (tx_r == TAP_W'(TAPS - 1)) begin
        tx_r <= '0;
        ty_r <= ty_r + 1'b1;
      end else begin
        tx_r <= tx_r + 1'b1;
      end
    end
  end

  // line store
  logic [23:0] line_mem [ROW_SLOTS * (1 << COL_W)];
  logic [23:0] rd_q_r;
  logic [WB-1:0] sw_q_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && is_pixel) begin
      line_mem[{ws, wc}] <= {in_data.chan_c, in_data.chan_b, in_data.chan_a};
    end
    if (rd_en) begin
      rd_q_r <= line_mem[rd_addr];
      sw_q_r <= SPACE_TAB[dist2];
    end
  end

  // weighting pipeline
  logic          vld_q_r, ctr_q_r, vld_a_r, vld_b_r;
  logic [23:0]   pc_r;
  logic [2*WB-1:0] prod_a_r [3];
  logic [7:0]      pix_a_r  [3];
  logic [WB+7:0]   wtp_b_r  [3];
  logic [WB-1:0]   wt_b_r   [3];
  logic [NUM_W-1:0] num_r   [3];
  logic [DEN_W-1:0] den_r   [3];
  logic [NUM_W-1:0] rem_r   [3];
  logic [7:0]       q_r     [3];
  logic [2:0]       bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
      ctr_q_r <= 1'b0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_q_r <= cmd.issue_tap;
      ctr_q_r <= cmd.issue_centre;
      vld_a_r <= vld_q_r;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0]    p;
    logic [7:0]    pcc;
    logic [7:0]    diff;
    logic [WB-1:0] wt;
    if (ctr_q_r) pc_r <= rd_q_r;
    for (int ch = 0; ch < 3; ch++) begin
      p    = rd_q_r[8*ch +: 8];
      pcc  = pc_r[8*ch +: 8];
      diff = (p > pcc) ? p - pcc : pcc - p;
      prod_a_r[ch] <= (2*WB)'(sw_q_r) * (2*WB)'(RANGE_TAB[diff]);
      pix_a_r[ch]  <= p;
      wt = prod_a_r[ch][2*WB-1:WB];
      wtp_b_r[ch] <= (WB+8)'(wt) * (WB+8)'(pix_a_r[ch]);
      wt_b_r[ch]  <= wt;
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] trial;
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.start) begin
        num_r[ch] <= '0;
        den_r[ch] <= '0;
      end else if (vld_b_r) begin
        num_r[ch] <= num_r[ch] + NUM_W'(wtp_b_r[ch]);
        den_r[ch] <= den_r[ch] + DEN_W'(wt_b_r[ch]);
      end
      trial = NUM_W'(den_r[ch]) << bit_r;
      if (cmd.div_init) begin
        rem_r[ch] <= num_r[ch];
        q_r[ch]   <= '0;
      end else if (cmd.div_step && rem_r[ch] >= trial) begin
        rem_r[ch]       <= rem_r[ch] - trial;
        q_r[ch][bit_r]  <= 1'b1;
      end
    end
    if (cmd.div_init)      bit_r <= 3'd7;
    else if (cmd.div_step) bit_r <= bit_r - 1'b1;
  end

  assign st.div_last = bit_r == 3'd0;

  // result register
  logic [7:0] res [3];
  out_item_t  out_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      res[ch] = (den_r[ch] == '0) ? pc_r[8*ch +: 8] : q_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.out_a     <= res[0];
      out_r.out_b     <= cfg.color_mode ? res[1] : 8'd0;
      out_r.out_c     <= cfg.color_mode ? res[2] : 8'd0;
      out_r.frame_end <= (o_row_r == cfg.height - 1'b1)
                      && (FRAME_W'(o_col_r) == cfg.width - 1'b1);
    end
  end

  assign out_data = out_r;

endmodule
